@@ sv/dhx_pkg.sv @@
// ----------------------------------------------------------------------------
// dhx_pkg: shared types and constants for the key exchange unit
// Word layouts, controller states and datapath command codes.
// ----------------------------------------------------------------------------
package dhx_pkg;

  localparam int unsigned KeyWidthDefault = 32;
  localparam int unsigned FieldWidth      = 32;
  localparam int unsigned MsgWidth        = 8;

  typedef struct packed {
    logic [MsgWidth-1:0]   message_byte;
    logic [FieldWidth-1:0] generator;
    logic [FieldWidth-1:0] own_private_exponent;
    logic [FieldWidth-1:0] modulus;
    logic [FieldWidth-1:0] partner_public_key;
    logic [FieldWidth-1:0] key_exponent;
  } dhx_in_t;

  typedef struct packed {
    logic [FieldWidth-1:0] own_public_key;
    logic [FieldWidth-1:0] shared_key;
    logic [FieldWidth-1:0] result_value;
    logic                  bad_modulus;
  } dhx_out_t;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StRedBase,
    StExpBit,
    StMulR,
    StMulB,
    StNextBit,
    StNextExp,
    StDone
  } dhx_state_e;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdRedStart,
    CmdSel2,
    CmdMulRStart,
    CmdMulBStart,
    CmdStep,
    CmdFinish
  } dhx_cmd_e;

  typedef struct packed {
    logic busy;      // multiplier or reducer still iterating
    logic exp_bit;   // current exponent bit
    logic last_bit;  // current bit is the last one
    logic bad_mod;   // captured modulus is zero
    logic second;    // working on the second exponentiation
  } dhx_status_t;

endpackage

@@ sv/dhx_datapath.sv @@
// ----------------------------------------------------------------------------
// dhx_datapath: operand registers and bit-serial modular multiplier
// One shift-and-add step per cycle; also reduces the base by the same unit.
// ----------------------------------------------------------------------------
module dhx_datapath #(
  parameter int unsigned KeyWidth = dhx_pkg::KeyWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dhx_pkg::dhx_cmd_e   cmd_i,
  input  dhx_pkg::dhx_in_t    in_word_i,
  output dhx_pkg::dhx_status_t status_o,
  output dhx_pkg::dhx_out_t   out_word_o
);

  localparam int unsigned CntW = $clog2(KeyWidth + 1);
  localparam int unsigned BitW = $clog2(KeyWidth);

  logic [KeyWidth-1:0] p_q, base2_q, exp2_q, exp_q, r_q, b_q, pub_q;
  logic [KeyWidth-1:0] acc_q, acc_d, ma_q, mb_q;
  logic [dhx_pkg::MsgWidth-1:0] msg_q;
  logic [BitW-1:0] bit_q;
  logic [CntW-1:0] mcnt_q;
  logic            mbusy_q, second_q, to_b_q;
  logic            red_q;  // multiplier reduces a raw base: a=1, b=base
  logic [KeyWidth-1:0] dbl, room_d, room_a, addend;

  // acc = 2*acc mod p, then + a mod p when the current bit of b is set.
  always_comb begin
    room_d = p_q - acc_q;
    dbl    = (acc_q >= room_d) ? (acc_q - room_d) : (acc_q + acc_q);
    room_a = p_q - ma_q;
    addend = (dbl >= room_a) ? (dbl - room_a) : (dbl + ma_q);
    acc_d  = mb_q[KeyWidth-1] ? addend : dbl;
  end

  // For base reduction, a=1 and b=base: the ladder computes base mod p,
  // but base bits may exceed p, so the add must still be modular with a=1<p.
  logic [KeyWidth-1:0] one_mod_p;
  assign one_mod_p = (p_q == KeyWidth'(1)) ? '0 : KeyWidth'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q  <= 1'b0;
      second_q <= 1'b0;
      mcnt_q   <= '0;
    end else begin
      if (mbusy_q) begin
        mcnt_q <= mcnt_q - CntW'(1);
        if (mcnt_q == CntW'(1)) mbusy_q <= 1'b0;
      end
      unique case (cmd_i)
        dhx_pkg::CmdLoad:      second_q <= 1'b0;
        dhx_pkg::CmdRedStart,
        dhx_pkg::CmdMulRStart,
        dhx_pkg::CmdMulBStart: begin
          mbusy_q <= 1'b1;
          mcnt_q  <= CntW'(KeyWidth);
        end
        dhx_pkg::CmdSel2:      second_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mbusy_q) begin
      acc_q <= acc_d;
      mb_q  <= {mb_q[KeyWidth-2:0], 1'b0};
      if (mcnt_q == CntW'(1)) begin
        if (red_q)       b_q <= acc_d;
        else if (to_b_q) b_q <= acc_d;
        else             r_q <= acc_d;
      end
    end
    unique case (cmd_i)
      dhx_pkg::CmdLoad: begin
        p_q     <= KeyWidth'(in_word_i.modulus);
        b_q     <= KeyWidth'(in_word_i.generator);
        exp_q   <= KeyWidth'(in_word_i.own_private_exponent);
        base2_q <= KeyWidth'(in_word_i.partner_public_key);
        exp2_q  <= KeyWidth'(in_word_i.key_exponent);
        msg_q   <= in_word_i.message_byte;
      end
      dhx_pkg::CmdSel2: begin
        pub_q <= r_q;
        b_q   <= base2_q;
        exp_q <= exp2_q;
      end
      dhx_pkg::CmdRedStart: begin
        ma_q <= one_mod_p; mb_q <= b_q; acc_q <= '0; red_q <= 1'b1;
        r_q <= one_mod_p; bit_q <= '0;
      end
      dhx_pkg::CmdMulRStart: begin
        ma_q <= r_q; mb_q <= b_q; acc_q <= '0; red_q <= 1'b0; to_b_q <= 1'b0;
      end
      dhx_pkg::CmdMulBStart: begin
        ma_q <= b_q; mb_q <= b_q; acc_q <= '0; red_q <= 1'b0; to_b_q <= 1'b1;
      end
      dhx_pkg::CmdStep: begin
        exp_q <= {1'b0, exp_q[KeyWidth-1:1]};
        bit_q <= bit_q + BitW'(1);
      end
      default: ;
    endcase
  end

  assign status_o.busy     = mbusy_q;
  assign status_o.exp_bit  = exp_q[0];
  assign status_o.last_bit = (bit_q == BitW'(KeyWidth - 1));
  assign status_o.bad_mod  = (p_q == '0);
  assign status_o.second   = second_q;

  localparam int unsigned FieldWidthL = dhx_pkg::FieldWidth;
  logic [FieldWidthL-1:0] pub_ext, sh_ext;
  if (KeyWidth >= FieldWidthL) begin : g_cut
    assign pub_ext = pub_q[FieldWidthL-1:0];
    assign sh_ext  = r_q[FieldWidthL-1:0];
  end else begin : g_ext
    assign pub_ext = {{(FieldWidthL-KeyWidth){1'b0}}, pub_q};
    assign sh_ext  = {{(FieldWidthL-KeyWidth){1'b0}}, r_q};
  end

  always_comb begin
    if (p_q == '0) begin
      out_word_o = '0;
      out_word_o.bad_modulus = 1'b1;
    end else begin
      out_word_o.own_public_key = pub_ext;
      out_word_o.shared_key     = sh_ext;
      out_word_o.result_value   = sh_ext ^ {{(FieldWidthL-dhx_pkg::MsgWidth){1'b0}}, msg_q};
      out_word_o.bad_modulus    = 1'b0;
    end
  end

endmodule

@@ sv/dhx_ctrl.sv @@
// ----------------------------------------------------------------------------
// dhx_ctrl: sequencer for the two square-and-multiply exponentiations
// Walks exponent bits LSB first and issues multiply commands.
// ----------------------------------------------------------------------------
module dhx_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  dhx_pkg::dhx_status_t status_i,
  output dhx_pkg::dhx_cmd_e    cmd_o
);

  dhx_pkg::dhx_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dhx_pkg::StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhx_pkg::StIdle:    if (in_valid_i) state_d = dhx_pkg::StLoad;
      dhx_pkg::StLoad:    state_d = status_i.bad_mod ? dhx_pkg::StDone
                                                     : dhx_pkg::StRedBase;
      dhx_pkg::StRedBase: state_d = dhx_pkg::StExpBit;
      dhx_pkg::StExpBit:  if (!status_i.busy)
                            state_d = status_i.exp_bit ? dhx_pkg::StMulR
                                                       : dhx_pkg::StMulB;
      dhx_pkg::StMulR:    state_d = dhx_pkg::StMulB;
      dhx_pkg::StMulB:    if (!status_i.busy) state_d = dhx_pkg::StNextBit;
      dhx_pkg::StNextBit: if (!status_i.busy)
                            state_d = status_i.last_bit ? dhx_pkg::StNextExp
                                                        : dhx_pkg::StExpBit;
      dhx_pkg::StNextExp: state_d = status_i.second ? dhx_pkg::StDone
                                                    : dhx_pkg::StRedBase;
      dhx_pkg::StDone:    if (!out_stall_i) state_d = dhx_pkg::StIdle;
      default:            state_d = dhx_pkg::StIdle;
    endcase
  end

  // Multiplies in StMulR must finish before StMulB starts; StMulB waits there.
  always_comb begin
    cmd_o = dhx_pkg::CmdNone;
    unique case (state_q)
      dhx_pkg::StIdle:    if (in_valid_i) cmd_o = dhx_pkg::CmdLoad;
      dhx_pkg::StRedBase: cmd_o = dhx_pkg::CmdRedStart;
      dhx_pkg::StMulR:    cmd_o = dhx_pkg::CmdMulRStart;
      dhx_pkg::StMulB:    if (!status_i.busy) cmd_o = dhx_pkg::CmdMulBStart;
      dhx_pkg::StNextBit: if (!status_i.busy) cmd_o = dhx_pkg::CmdStep;
      dhx_pkg::StNextExp: if (!status_i.second) cmd_o = dhx_pkg::CmdSel2;
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != dhx_pkg::StIdle);
  assign out_valid_o = (state_q == dhx_pkg::StDone);

endmodule

@@ sv/diffie_hellman_xor_byte_unit.sv @@
// ----------------------------------------------------------------------------
// diffie_hellman_xor_byte_unit: modular exponentiation key exchange with XOR
// Each of the 2*KEY_WIDTH exponent bits takes a squaring, preceded by a multiply
// into the result when the bit is set, all on the one bit-serial multiplier;
// a zero modulus skips both exponentiations and goes straight to the result.
// One word in flight; the next word is accepted once the result has been taken.
// Reset returns the controller to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module diffie_hellman_xor_byte_unit #(
  parameter int unsigned KEY_WIDTH = dhx_pkg::KeyWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dhx_pkg::dhx_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dhx_pkg::dhx_out_t out_data_o
);

  dhx_pkg::dhx_cmd_e    cmd;
  dhx_pkg::dhx_status_t status;

  dhx_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  dhx_datapath #(.KeyWidth(KEY_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_word_i(in_data_i),
    .status_o(status), .out_word_o(out_data_o)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for diffie_hellman_xor_byte_unit
// Drives key exchange requests with random gaps and output stalls and checks
// each result word against a modular exponentiation predictor.
// ----------------------------------------------------------------------------
module testbench;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  dhx_pkg::dhx_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  dhx_pkg::dhx_out_t out_data_o;

  dhx_pkg::dhx_out_t expected_words[$];
  int       mismatches = 0;
  bit       hold_output = 1'b0;

  diffie_hellman_xor_byte_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Product modulo p by shift-and-add; operands are already below p.
  function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] p);
    logic [63:0] acc;
    acc = 0;
    for (int i = 63; i >= 0; i--) begin
      acc = (acc >= p - acc) ? acc - (p - acc) : acc + acc;
      if (b[i]) acc = (acc >= p - a) ? acc - (p - a) : acc + a;
    end
    return acc;
  endfunction

  function automatic logic [31:0] mod_power(logic [31:0] base, logic [31:0] e,
                                            logic [31:0] p);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd1 % p;
    b = base % p;
    for (int i = 0; i < 32; i++) begin
      if (e[i]) r = mod_product(r, b, p);
      b = mod_product(b, b, p);
    end
    return r[31:0];
  endfunction

  function automatic dhx_pkg::dhx_out_t predict_exchange(dhx_pkg::dhx_in_t w);
    dhx_pkg::dhx_out_t o;
    o = '0;
    if (w.modulus == 0) begin
      o.bad_modulus = 1'b1;
    end else begin
      o.own_public_key = mod_power(w.generator, w.own_private_exponent, w.modulus);
      o.shared_key = mod_power(w.partner_public_key, w.key_exponent, w.modulus);
      o.result_value = o.shared_key ^ {24'd0, w.message_byte};
    end
    return o;
  endfunction

  // Valid stays high into the next word when no gap is drawn.
  task automatic send_word(dhx_pkg::dhx_in_t w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    expected_words.push_back(predict_exchange(w));
  endtask

  // Stall pattern: a fresh random wait before each result, held on while hold_output is set.
  initial begin
    int wait_cycles;
    forever begin
      wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
      if (wait_cycles != 0 || hold_output) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
        while (hold_output) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data_o);
      end else begin
        dhx_pkg::dhx_out_t e;
        e = expected_words.pop_front();
        if (e.own_public_key != out_data_o.own_public_key ||
            e.shared_key != out_data_o.shared_key ||
            e.result_value != out_data_o.result_value ||
            e.bad_modulus != out_data_o.bad_modulus) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                     e.own_public_key, e.shared_key, e.result_value, e.bad_modulus,
                     out_data_o.own_public_key, out_data_o.shared_key,
                     out_data_o.result_value, out_data_o.bad_modulus);
        end
      end
    end
  end

  function automatic logic [31:0] random_field();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 20);
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    dhx_pkg::dhx_in_t w;
    logic [31:0] corner[4] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFB};
    foreach (corner[i]) begin
      w = '{8'hFF, corner[i], corner[3 - i], corner[i], corner[(i + 1) % 4],
            corner[(i + 2) % 4]};
      send_word(w);
    end
    send_word('{8'h00, 32'd7, 32'd0, 32'd1, 32'd9, 32'd0});
    send_word('{8'hA5, 32'd5, 32'd6, 32'd23, 32'd8, 32'd15});
    send_word('{8'h5A, 32'd100, 32'd3, 32'd23, 32'd50, 32'd2});
    send_word('{8'h3C, 32'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                32'h8000_0001});
    send_word('{8'h81, 32'd3, 32'd4, 32'd0, 32'd5, 32'd6});
    send_word('{8'h01, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0});
    in_valid_i <= 1'b0;
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      dhx_pkg::dhx_in_t w;
      w.message_byte = 8'($urandom());
      w.generator = random_field();
      w.own_private_exponent = random_field();
      w.modulus = random_field();
      w.partner_public_key = random_field();
      w.key_exponent = random_field();
      send_word(w);
    end
    in_valid_i <= 1'b0;
  endtask

  // The receiver holds off while the sender keeps offering words.
  task automatic test_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (20000) @(posedge clk_i);
        hold_output = 1'b0;
      end
      test_random(4);
    join
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random(116);
    wait_drained();
    repeat (7000) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #40000000;
    $display("status: fail");
    $finish;
  end
endmodule
